// ===== rtl/sih_pkg.sv =====
`default_nettype none
package sih_pkg;
	localparam int INDEX_BITS_DEF = 10;
	localparam int MAX_NAME_LEN_DEF = 16;
	localparam int MAX_RESULTS = 16;
	localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
	localparam logic [31:0] HASH_MULT = (32'd1 << 24) + (32'd1 << 8) + 32'h93;
	localparam logic [6:0] LEN_SAT = 7'd127;

	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_ADD = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_TOO_LONG = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_WRITE,
		S_READ_RD,
		S_READ_CHK,
		S_READ_NXT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [9:0] result_id;
		logic       found;
		logic [1:0] status;
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_result;
	} res_t;
endpackage
`default_nettype wire

// ===== rtl/sih_if.sv =====
`default_nettype none
interface sih_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_byte;
	logic       last_char;
	logic [9:0] entry_id;
	modport source(output valid, kind, char_byte, last_char, entry_id, input ready);
	modport sink(input valid, kind, char_byte, last_char, entry_id, output ready);
endinterface

interface sih_out_if;
	logic       valid;
	logic       ready;
	logic [9:0] result_id;
	logic       found;
	logic [1:0] status;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last_result;
	modport source(output valid, result_id, found, status, out_byte, byte_valid,
		last_result, input ready);
	modport sink(input valid, result_id, found, status, out_byte, byte_valid,
		last_result, output ready);
endinterface
`default_nettype wire

// ===== rtl/string_intern_hash_table_core.sv =====
// String intern table with FNV-1a hashing and linear probing.
// Input channel (in_ch): one transaction per name byte (kind 0 lookup,
// kind 1 lookup-or-add) or one read-by-id transaction (kind 2).
// Output channel (out_ch): one transaction per result, last_result marks
// the final result of an input.
// A non-last name byte is captured, then folded in one shared multiplier pass.
// A last name byte then probes: every compared byte takes a memory
// address step, then a compare step. An add then writes MAX_NAME_LEN
// bytes, one per cycle, through the single write port.
// A read emits one transaction per stored byte, each through address,
// capture, look-ahead for the terminator and output, or a single
// transaction through address, capture and output for an empty slot.
// Everything runs through one byte-wide name memory port, one compare and
// one multiplier, so the block holds ready low while an item is in work.
// After reset a clearing pass writes zero to every store byte, with ready
// low throughout.
// A result sits in the output register until taken; a stalled receiver
// holds the block in its output state, and no input is taken meanwhile.
`default_nettype none
module string_intern_hash_table_core #(
	parameter int INDEX_BITS = sih_pkg::INDEX_BITS_DEF,
	parameter int MAX_NAME_LEN = sih_pkg::MAX_NAME_LEN_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	sih_in_if.sink   in_ch,
	sih_out_if.source out_ch
);
	localparam int LB = $clog2(MAX_NAME_LEN);
	localparam int AW = INDEX_BITS + LB;
	localparam int NSLOTS = 1 << INDEX_BITS;
	localparam int CW = LB + 1;
	localparam int RD_CAP = (MAX_NAME_LEN < sih_pkg::MAX_RESULTS) ? MAX_NAME_LEN
		: sih_pkg::MAX_RESULTS;

	logic [7:0] mem [(1 << AW)];
	logic [7:0] name_buf_q [MAX_NAME_LEN];

	sih_pkg::state_t state_q, state_d;
	logic [31:0] hash_q;
	logic [6:0]  len_q;
	logic        too_long_q;
	logic        add_q;
	logic [AW-1:0] clr_q;
	logic [INDEX_BITS-1:0] slot_q;
	logic [INDEX_BITS:0]   probes_q;
	logic [CW-1:0] pos_q;
	logic [7:0] rd_q;
	logic [7:0] byte_q;
	logic [1:0] kind_q;
	logic       last_q;
	sih_pkg::res_t res_q;
	logic       out_valid_q;

	// Shared multiplier: (hash ^ byte) * prime, truncated.
	logic [31:0] mul_res;
	assign mul_res = (hash_q ^ {24'd0, byte_q}) * sih_pkg::HASH_MULT;

	logic [LB-1:0] pos_i;
	assign pos_i = pos_q[LB-1:0];
	logic [LB-1:0] pos_nxt;
	assign pos_nxt = pos_i + 1'b1;
	logic [CW-1:0] len_c;
	assign len_c = (len_q > 7'(MAX_NAME_LEN)) ? CW'(MAX_NAME_LEN) : len_q[CW-1:0];
	// past the end of the name, compare against the terminator
	logic [7:0] buf_b;
	assign buf_b = (pos_q < len_c) ? name_buf_q[pos_i] : 8'd0;

	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	logic [7:0]    wr_data;
	// while a read byte is captured, look one byte ahead for the terminator
	assign rd_addr = (state_q == sih_pkg::S_READ_CHK) ? {slot_q, pos_nxt} : {slot_q, pos_i};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = clr_q;
		wr_data = 8'd0;
		if (state_q == sih_pkg::S_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == sih_pkg::S_WRITE) begin
			wr_en = 1'b1;
			wr_addr = {slot_q, pos_i};
			wr_data = (pos_q < len_c) ? name_buf_q[pos_i] : 8'd0;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sih_pkg::S_CLEAR: if (clr_q == '1) state_d = sih_pkg::S_IDLE;
			sih_pkg::S_IDLE: begin
				if (in_ch.valid) begin
					if (in_ch.kind == sih_pkg::KIND_READ) state_d = sih_pkg::S_READ_RD;
					else if (in_ch.kind != sih_pkg::KIND_NONE) state_d = sih_pkg::S_HASH;
				end
			end
			sih_pkg::S_HASH: begin
				if (!last_q) state_d = sih_pkg::S_IDLE;
				else if (too_long_q || (byte_q != 8'd0 && len_q >= 7'(MAX_NAME_LEN))
					|| (len_q == 7'd0 && byte_q == 8'd0)) state_d = sih_pkg::S_OUT;
				else state_d = sih_pkg::S_PROBE_RD;
			end
			sih_pkg::S_PROBE_RD: begin
				if (probes_q == (INDEX_BITS+1)'(NSLOTS)) state_d = sih_pkg::S_OUT;
				else state_d = sih_pkg::S_PROBE_CHK;
			end
			sih_pkg::S_PROBE_CHK: begin
				if (pos_q == '0 && rd_q == 8'd0) state_d = add_q ? sih_pkg::S_WRITE
					: sih_pkg::S_OUT;
				else if (rd_q != buf_b) state_d = sih_pkg::S_PROBE_RD;
				else if (pos_q == len_c || pos_q == CW'(MAX_NAME_LEN - 1)
					&& len_c == CW'(MAX_NAME_LEN))
					state_d = sih_pkg::S_OUT;
				else state_d = sih_pkg::S_PROBE_RD;
			end
			sih_pkg::S_WRITE: if (pos_q == CW'(MAX_NAME_LEN - 1)) state_d = sih_pkg::S_OUT;
			sih_pkg::S_READ_RD: state_d = sih_pkg::S_READ_CHK;
			sih_pkg::S_READ_CHK: begin
				if ((pos_q == '0 && rd_q == 8'd0) || pos_q == CW'(RD_CAP - 1))
					state_d = sih_pkg::S_OUT;
				else state_d = sih_pkg::S_READ_NXT;
			end
			sih_pkg::S_READ_NXT: state_d = sih_pkg::S_OUT;
			sih_pkg::S_OUT: begin
				if (out_ch.ready) begin
					if (res_q.last_result) state_d = sih_pkg::S_IDLE;
					else state_d = sih_pkg::S_READ_RD;
				end
			end
			default: state_d = sih_pkg::S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ch.ready = (state_q == sih_pkg::S_IDLE);
		out_ch.valid = out_valid_q;
		out_ch.result_id = res_q.result_id;
		out_ch.found = res_q.found;
		out_ch.status = res_q.status;
		out_ch.out_byte = res_q.out_byte;
		out_ch.byte_valid = res_q.byte_valid;
		out_ch.last_result = res_q.last_result;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sih_pkg::S_CLEAR;
			clr_q <= '0;
			hash_q <= sih_pkg::FNV_OFFSET;
			len_q <= '0;
			too_long_q <= 1'b0;
			out_valid_q <= 1'b0;
			add_q <= 1'b0;
			slot_q <= '0;
			probes_q <= '0;
			pos_q <= '0;
			kind_q <= '0;
			last_q <= 1'b0;
			byte_q <= '0;
			res_q <= '0;
			for (int i = 0; i < MAX_NAME_LEN; i++) name_buf_q[i] <= 8'd0;
		end else begin
			state_q <= state_d;
			case (state_q)
				sih_pkg::S_CLEAR: clr_q <= clr_q + 1'b1;
				sih_pkg::S_IDLE: begin
					if (in_ch.valid) begin
						kind_q <= in_ch.kind;
						byte_q <= in_ch.char_byte;
						last_q <= in_ch.last_char;
						add_q <= (in_ch.kind == sih_pkg::KIND_ADD);
						slot_q <= INDEX_BITS'(in_ch.entry_id);
						pos_q <= '0;
					end
				end
				sih_pkg::S_HASH: begin
					// fold the byte, then either wait or set up the probe
					logic [31:0] h;
					logic [6:0]  l;
					logic        tl;
					logic [15:0] f;
					h = hash_q;
					l = len_q;
					tl = too_long_q;
					if (byte_q != 8'd0) begin
						h = mul_res;
						if (len_q < 7'(MAX_NAME_LEN)) name_buf_q[len_q[LB-1:0]] <= byte_q;
						else tl = 1'b1;
						if (len_q < sih_pkg::LEN_SAT) l = len_q + 7'd1;
					end
					hash_q <= h;
					len_q <= l;
					too_long_q <= tl;
					f = h[31:16] ^ h[15:0];
					slot_q <= INDEX_BITS'(f);
					probes_q <= '0;
					pos_q <= '0;
					if (last_q) begin
						res_q <= '{result_id: '0, found: 1'b0,
							status: tl ? sih_pkg::ST_TOO_LONG : sih_pkg::ST_OK,
							out_byte: 8'd0, byte_valid: 1'b0, last_result: 1'b1};
						if (tl || l == 7'd0) out_valid_q <= 1'b1;
					end
				end
				sih_pkg::S_PROBE_RD: begin
					if (probes_q == (INDEX_BITS+1)'(NSLOTS)) begin
						res_q.status <= sih_pkg::ST_FULL;
						out_valid_q <= 1'b1;
					end
				end
				sih_pkg::S_PROBE_CHK: begin
					if (pos_q == '0 && rd_q == 8'd0) begin
						if (add_q) res_q.result_id <= 10'(slot_q);
						else out_valid_q <= 1'b1;
					end else if (rd_q != buf_b) begin
						slot_q <= slot_q + 1'b1;
						probes_q <= probes_q + 1'b1;
						pos_q <= '0;
					end else if (pos_q == len_c || pos_q == CW'(MAX_NAME_LEN - 1)
						&& len_c == CW'(MAX_NAME_LEN)) begin
						res_q.result_id <= 10'(slot_q);
						res_q.found <= 1'b1;
						out_valid_q <= 1'b1;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				sih_pkg::S_WRITE: begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == CW'(MAX_NAME_LEN - 1)) out_valid_q <= 1'b1;
				end
				sih_pkg::S_READ_CHK: begin
					res_q.result_id <= 10'(slot_q);
					res_q.status <= sih_pkg::ST_OK;
					if (pos_q == '0 && rd_q == 8'd0) begin
						// empty slot: one result carrying no byte
						res_q.out_byte <= 8'd0;
						res_q.byte_valid <= 1'b0;
						res_q.found <= 1'b0;
						res_q.last_result <= 1'b1;
						out_valid_q <= 1'b1;
					end else begin
						res_q.out_byte <= rd_q;
						res_q.byte_valid <= 1'b1;
						res_q.found <= 1'b1;
						// at the read cap the byte is last without a look-ahead
						if (pos_q == CW'(RD_CAP - 1)) begin
							res_q.last_result <= 1'b1;
							out_valid_q <= 1'b1;
						end
					end
				end
				sih_pkg::S_READ_NXT: begin
					// a zero after this byte ends the stored name
					res_q.last_result <= (rd_q == 8'd0);
					out_valid_q <= 1'b1;
				end
				sih_pkg::S_OUT: begin
					if (out_ch.ready) begin
						out_valid_q <= 1'b0;
						pos_q <= pos_q + 1'b1;
						if (res_q.last_result && kind_q != sih_pkg::KIND_READ) begin
							hash_q <= sih_pkg::FNV_OFFSET;
							len_q <= '0;
							too_long_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire
